### hw/rtl/lpfd_pkg.sv
// Shared types and character codes for the length-prefixed field deframer
`timescale 1ns / 1ps

package lpfd_pkg;

  // default sizes
  localparam int unsigned LenBitsDef  = 16;
  localparam int unsigned LenCharsDef = 10;

  // framing characters
  localparam logic [7:0] ChOpen    = 8'h7B;  // '{'
  localparam logic [7:0] ChClose   = 8'h7D;  // '}'
  localparam logic [7:0] ChLength  = 8'h4C;  // 'L'
  localparam logic [7:0] ChPayload = 8'h43;  // 'C'
  localparam logic [7:0] ChZero    = 8'h30;  // '0'
  localparam logic [7:0] ChNine    = 8'h39;  // '9'

  // field counter saturates here; fields at this count are not emitted
  localparam logic [1:0] FieldSat = 2'd3;

  typedef enum logic [1:0] {
    MODE_HUNT    = 2'd0,
    MODE_FRAME   = 2'd1,
    MODE_LENGTH  = 2'd2,
    MODE_PAYLOAD = 2'd3
  } mode_e;

  // one result transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] field_index;
    logic       field_last;
    logic       field_empty;
    logic       frame_end;
  } result_t;

endpackage

### hw/rtl/lpfd_in_stage.sv
// Input register for received bytes
`timescale 1ns / 1ps

module lpfd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // free when empty or when the held byte is consumed this cycle
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

### hw/rtl/lpfd_parser.sv
// Frame parser state and per-byte result logic
`timescale 1ns / 1ps

module lpfd_parser
  import lpfd_pkg::*;
#(
  parameter int unsigned LenBits  = LenBitsDef,
  parameter int unsigned LenChars = LenCharsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int unsigned CntW = $clog2(LenChars + 1);
  localparam int unsigned ProdW = LenBits + 4;

  mode_e               mode_q, mode_d;
  logic [LenBits-1:0]  len_q, len_d;
  logic [CntW-1:0]     chars_q, chars_d;
  logic                frozen_q, frozen_d;
  logic [LenBits-1:0]  rem_q, rem_d;
  logic [1:0]          fcnt_q, fcnt_d;

  logic [ProdW-1:0]    len_ext, prod;
  logic [LenBits-1:0]  len_sat;
  logic [LenBits-1:0]  rem_dec;
  logic                is_digit;
  logic                start_pl;
  logic [1:0]          fcnt_inc;

  // decimal accumulate with saturation
  assign len_ext  = ProdW'(len_q);
  assign prod     = (len_ext << 3) + (len_ext << 1) + ProdW'(byte_i[3:0]);
  assign len_sat  = (|prod[ProdW-1:LenBits]) ? {LenBits{1'b1}} : prod[LenBits-1:0];
  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign rem_dec  = (rem_q != '0) ? rem_q - LenBits'(1) : rem_q;
  assign fcnt_inc = (fcnt_q != FieldSat) ? fcnt_q + 2'd1 : fcnt_q;

  // next state and result
  always_comb begin
    mode_d      = mode_q;
    len_d       = len_q;
    chars_d     = chars_q;
    frozen_d    = frozen_q;
    rem_d       = rem_q;
    fcnt_d      = fcnt_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    start_pl    = 1'b0;

    unique case (mode_q)
      MODE_HUNT: begin
        if (byte_i == ChOpen) begin
          mode_d = MODE_FRAME;
        end
      end
      MODE_FRAME: begin
        if (byte_i == ChClose) begin
          mode_d          = MODE_HUNT;
          len_d           = '0;
          chars_d         = '0;
          frozen_d        = 1'b0;
          rem_d           = '0;
          fcnt_d          = '0;
          res_valid_o     = 1'b1;
          res_o.frame_end = 1'b1;
        end else if (byte_i == ChLength) begin
          mode_d   = MODE_LENGTH;
          len_d    = '0;
          chars_d  = '0;
          frozen_d = 1'b0;
        end else if (byte_i == ChPayload) begin
          start_pl = 1'b1;
        end
      end
      MODE_LENGTH: begin
        if (byte_i == ChPayload) begin
          start_pl = 1'b1;
        end else if (chars_q >= CntW'(LenChars)) begin
          // too many length characters, drop back to frame level
          mode_d = MODE_FRAME;
        end else begin
          chars_d = chars_q + CntW'(1);
          if (!frozen_q) begin
            if (is_digit) begin
              len_d = len_sat;
            end else begin
              frozen_d = 1'b1;
            end
          end
        end
      end
      MODE_PAYLOAD: begin
        rem_d = rem_dec;
        if (fcnt_q != FieldSat) begin
          res_valid_o       = 1'b1;
          res_o.data_byte   = byte_i;
          res_o.field_index = fcnt_q;
          res_o.field_last  = (rem_dec == '0);
        end
        if (rem_dec == '0) begin
          fcnt_d = fcnt_inc;
          mode_d = MODE_FRAME;
        end
      end
      default: begin
        mode_d = MODE_HUNT;
      end
    endcase

    // payload start: empty field gives a marker, otherwise load the count
    if (start_pl) begin
      if (len_q == '0) begin
        if (fcnt_q != FieldSat) begin
          res_valid_o       = 1'b1;
          res_o.field_index = fcnt_q;
          res_o.field_last  = 1'b1;
          res_o.field_empty = 1'b1;
        end
        fcnt_d = fcnt_inc;
        mode_d = MODE_FRAME;
      end else begin
        rem_d  = len_q;
        mode_d = MODE_PAYLOAD;
      end
    end
  end

  // state registers, updated once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_HUNT;
      len_q    <= '0;
      chars_q  <= '0;
      frozen_q <= 1'b0;
      rem_q    <= '0;
      fcnt_q   <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      len_q    <= len_d;
      chars_q  <= chars_d;
      frozen_q <= frozen_d;
      rem_q    <= rem_d;
      fcnt_q   <= fcnt_d;
    end
  end

endmodule

### hw/rtl/length_prefixed_field_deframer.sv
// Top level of the length-prefixed field deframer
`timescale 1ns / 1ps

// Deframes a byte stream of the form '{' then repeated 'L' <decimal length> 'C'
// <payload>, closed by '}'. Each payload byte of the first three fields comes out
// with its field index (command, file name, content) and a last flag; a zero-length
// field among them gives one empty marker, and '}' gives a frame_end transaction.
// One byte is accepted every clock cycle. An accepted byte passes through an input
// register, then the parser's next-state logic, whose state update is registered
// together with its result in the result register. Bytes that cause no result are
// consumed without holding up the stream; backpressure on the output stalls input
// only while the result register stays full.
module length_prefixed_field_deframer
  import lpfd_pkg::*;
#(
  parameter int unsigned LenBits  = LenBitsDef,
  parameter int unsigned LenChars = LenCharsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic [1:0] field_index_o,
  output logic       field_last_o,
  output logic       field_empty_o,
  output logic       frame_end_o
);

  logic       st_valid;
  logic [7:0] st_byte;
  logic       step;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;

  // parser steps when the result register can take whatever it produces
  assign step = st_valid && (!out_valid_q || out_ready_i);

  lpfd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (step),
    .valid_o    (st_valid),
    .byte_o     (st_byte)
  );

  lpfd_parser #(
    .LenBits  (LenBits),
    .LenChars (LenChars)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (st_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_comb begin
    if (step) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_byte_o   = out_q.data_byte;
  assign field_index_o = out_q.field_index;
  assign field_last_o  = out_q.field_last;
  assign field_empty_o = out_q.field_empty;
  assign frame_end_o   = out_q.frame_end;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the length-prefixed field deframer
`timescale 1ns / 1ps

module testbench;
  import lpfd_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomBytes = 850;
  localparam int unsigned MaxGap      = 12;
  localparam int unsigned LenMax      = (1 << LenBitsDef) - 1;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] data_byte_o;
  logic [1:0] field_index_o;
  logic       field_last_o;
  logic       field_empty_o;
  logic       frame_end_o;

  // byte stream waiting to be sent, and results still owed by the block
  logic [7:0]  rx_q[$];
  result_t     expected_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // shadow parser state
  mode_e                 pm;
  logic [LenBitsDef-1:0] len_val;
  int unsigned           len_seen;
  bit                    len_frozen;
  logic [LenBitsDef-1:0] remaining;
  logic [1:0]            fcount;

  // last length the generator put in the current frame
  int unsigned gen_len;

  length_prefixed_field_deframer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_byte_o  (data_byte_o),
    .field_index_o(field_index_o),
    .field_last_o (field_last_o),
    .field_empty_o(field_empty_o),
    .frame_end_o  (frame_end_o)
  );

  always #10 clk_i = ~clk_i;

  // back to hunting with every length and count cleared
  function automatic void clear_parser();
    pm         = MODE_HUNT;
    len_val    = '0;
    len_seen   = 0;
    len_frozen = 1'b0;
    remaining  = '0;
    fcount     = '0;
  endfunction

  // 'C' seen: zero length gives an empty marker, otherwise a payload opens
  function automatic bit open_payload(output result_t r);
    bit hit;
    hit = 1'b0;
    r   = '0;
    if (len_val == '0) begin
      if (fcount < FieldSat) begin
        r.field_index = fcount;
        r.field_last  = 1'b1;
        r.field_empty = 1'b1;
        hit           = 1'b1;
        fcount        = fcount + 2'd1;
      end
      pm = MODE_FRAME;
    end else begin
      remaining = len_val;
      pm        = MODE_PAYLOAD;
    end
    return hit;
  endfunction

  // advance the shadow parser by one byte; returns 1 when a result is due
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    bit          hit;
    int unsigned acc;
    hit = 1'b0;
    r   = '0;
    case (pm)
      MODE_HUNT: begin
        if (b == ChOpen) pm = MODE_FRAME;
      end
      MODE_FRAME: begin
        if (b == ChClose) begin
          clear_parser();
          r.frame_end = 1'b1;
          hit         = 1'b1;
        end else if (b == ChLength) begin
          len_val    = '0;
          len_seen   = 0;
          len_frozen = 1'b0;
          pm         = MODE_LENGTH;
        end else if (b == ChPayload) begin
          hit = open_payload(r);
        end
      end
      MODE_LENGTH: begin
        if (b == ChPayload) begin
          hit = open_payload(r);
        end else if (len_seen >= LenCharsDef) begin
          pm = MODE_FRAME;
        end else begin
          len_seen++;
          if (!len_frozen) begin
            if (b >= ChZero && b <= ChNine) begin
              acc     = 32'(len_val) * 32'd10 + 32'(b - ChZero);
              len_val = (acc > LenMax) ? LenBitsDef'(LenMax) : LenBitsDef'(acc);
            end else begin
              len_frozen = 1'b1;
            end
          end
        end
      end
      default: begin
        if (remaining != '0) remaining = remaining - LenBitsDef'(1);
        if (fcount < FieldSat) begin
          r.data_byte   = b;
          r.field_index = fcount;
          r.field_last  = (remaining == '0);
          hit           = 1'b1;
        end
        if (remaining == '0) begin
          if (fcount < FieldSat) fcount = fcount + 2'd1;
          pm = MODE_FRAME;
        end
      end
    endcase
    return hit;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $realtime, msg);
    error_count++;
  endtask

  // compare one received transaction with the oldest pending one
  task automatic check_result(input result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      log_mismatch($sformatf("result %p with nothing pending", got));
      return;
    end
    want = expected_q.pop_front();
    if (got.data_byte != want.data_byte)
      log_mismatch($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
    if (got.field_index != want.field_index)
      log_mismatch($sformatf("field_index %0d, want %0d", got.field_index,
                             want.field_index));
    if (got.field_last != want.field_last)
      log_mismatch($sformatf("field_last %0b, want %0b", got.field_last, want.field_last));
    if (got.field_empty != want.field_empty)
      log_mismatch($sformatf("field_empty %0b, want %0b", got.field_empty,
                             want.field_empty));
    if (got.frame_end != want.frame_end)
      log_mismatch($sformatf("frame_end %0b, want %0b", got.frame_end, want.frame_end));
  endtask

  // stimulus helpers
  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_q.push_back(s[i]);
  endtask

  task automatic push_payload(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) rx_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // 'L', zero-padded decimal length, 'C'
  task automatic push_length(input int unsigned n, input int unsigned width);
    string s;
    s = $sformatf("%0d", n);
    while (s.len() < width) s = {"0", s};
    push_text({"L", s, "C"});
    gen_len = n;
  endtask

  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ChLength || b == ChPayload || b == ChClose);
    return b;
  endfunction

  // one frame: mostly well-formed fields with random content, some broken ones
  task automatic push_frame();
    int unsigned nfields;
    int unsigned len;
    int unsigned kind;
    string       digits;
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) rx_q.push_back(ChClose);
      else rx_q.push_back(stray_byte());
    end
    rx_q.push_back(ChOpen);
    gen_len = 0;
    nfields = $urandom_range(1, 5);
    for (int unsigned f = 0; f < nfields; f++) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
      kind = $urandom_range(0, 19);
      case (kind)
        // payload reusing the last length of the frame
        0: begin
          rx_q.push_back(ChPayload);
          push_payload(gen_len);
        end
        // stray byte ahead of a normal field
        1: begin
          rx_q.push_back(stray_byte());
          push_length(len, 1);
          push_payload(len);
        end
        // non-digit freezes the length
        2: begin
          digits = ($urandom_range(0, 1) == 0) ? "-" : " ";
          push_text({"L", $sformatf("%0d", len), digits, "7C"});
          gen_len = len;
          push_payload(len);
        end
        // full-width length, then either 'C' or one byte too many
        3: begin
          if ($urandom_range(0, 1) == 0) begin
            push_length(len, LenCharsDef);
            push_payload(len);
          end else begin
            push_text("L0000000000");
            rx_q.push_back(stray_byte());
            gen_len = 0;
          end
        end
        // empty length
        4: begin
          push_text("LC");
          gen_len = 0;
        end
        default: begin
          push_length(len, $urandom_range(1, 4));
          push_payload(len);
        end
      endcase
    end
    // occasionally leave the frame open
    if ($urandom_range(0, 14) != 0) rx_q.push_back(ChClose);
  endtask

  // input driver: predicts on every accepted transaction
  int unsigned gap_left = 0;
  bit          drv_burst = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    result_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'h00;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (deframe_byte(rx_byte_i, r)) expected_q.push_back(r);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (rx_q.size() > 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_q.pop_front();
          if ($urandom_range(0, 39) == 0) drv_burst = ~drv_burst;
          gap_left <= drv_burst ? 0 : $urandom_range(0, MaxGap);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor with random backpressure
  int unsigned stall_left = 0;
  bit          mon_burst = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned n;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && out_ready_i) begin
      check_result({data_byte_o, field_index_o, field_last_o, field_empty_o, frame_end_o});
      if ($urandom_range(0, 39) == 0) mon_burst = ~mon_burst;
      n = mon_burst ? 0 : $urandom_range(0, MaxGap);
      stall_left  <= n;
      out_ready_i <= (n == 0);
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clear_parser();
    gen_len = 0;

    // directed: bytes ignored while hunting, repeated open brace, stray byte,
    // payload without length, single byte, frozen length, fourth field, close
    push_text("}a{{qC");
    push_text("L1C");
    rx_q.push_back(8'hFF);
    push_text("L-3CL2C}");
    rx_q.push_back(8'h00);
    rx_q.push_back(ChPayload);
    rx_q.push_back(8'h80);
    rx_q.push_back(ChOpen);
    rx_q.push_back(ChClose);
    // directed: saturating length that also runs one character too long
    push_text("{L99999999999}");

    while (rx_q.size() < RandomBytes + 40) push_frame();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (error_count == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
